[hw/rtl/hrl_pkg.sv]
// ----------------------------------------------------------------------------
// hrl_pkg
// Shared types and constants for the http request lexer.
// ----------------------------------------------------------------------------
package hrl_pkg;

  // character codes
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // token kinds
  typedef enum logic [2:0] {
    KIND_METHOD  = 3'd0,
    KIND_URI     = 3'd1,
    KIND_VERSION = 3'd2,
    KIND_HEADER  = 3'd3,
    KIND_COLON   = 3'd4,
    KIND_VALUE   = 3'd5,
    KIND_NUMBER  = 3'd6,
    KIND_NONE    = 3'd7
  } kind_t;

  // request line words kept
  localparam logic [1:0] WORD_LIMIT = 2'd3;

  // result buffer depth and pointer width
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } hrl_in_t;

  // result item
  typedef struct packed {
    logic [2:0] tok_kind;
    logic [7:0] tok_byte;
    logic       tok_first;
    logic       tok_last;
    logic       msg_done;
  } hrl_out_t;

  // results of one step toward the buffer
  typedef struct packed {
    logic [1:0] count;
    hrl_out_t   res0;
    hrl_out_t   res1;
  } hrl_push_t;

endpackage

[hw/rtl/hrl_step.sv]
// ----------------------------------------------------------------------------
// hrl_step
// Lexer state and per-byte classification; yields up to two results a byte.
// ----------------------------------------------------------------------------
module hrl_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  hrl_pkg::hrl_in_t  data,
  output hrl_pkg::hrl_push_t push
);
  import hrl_pkg::*;

  logic       in_request_line;
  logic [1:0] word_index;
  kind_t      cur_kind;
  logic       after_colon;
  logic       held_valid;
  logic [7:0] held_byte;
  kind_t      held_kind;
  logic       held_first;

  logic       in_request_line_next;
  logic [1:0] word_index_next;
  kind_t      cur_kind_next;
  logic       after_colon_next;
  logic       held_valid_next;
  logic [7:0] held_byte_next;
  kind_t      held_kind_next;
  logic       held_first_next;

  logic       cont;
  logic       start;
  kind_t      nk;
  logic       digit;
  logic [7:0] b;
  hrl_out_t   e0;
  hrl_out_t   e1;
  hrl_out_t   none_res;
  logic       e1_valid;

  assign b     = data.in_byte;
  assign digit = (b >= CH_ZERO) && (b <= CH_NINE);

  // classify the byte against the open token
  always_comb begin
    cont                 = 1'b0;
    start                = 1'b0;
    nk                   = KIND_NONE;
    in_request_line_next = in_request_line;
    word_index_next      = word_index;
    after_colon_next     = after_colon;
    if (in_request_line) begin
      if (b == CH_CR) begin
        in_request_line_next = 1'b0;
      end else if (b == CH_SP) begin
        cont = 1'b0;
      end else if (cur_kind != KIND_NONE) begin
        cont = 1'b1;
      end else if (word_index < WORD_LIMIT) begin
        start           = 1'b1;
        nk              = kind_t'({1'b0, word_index});
        word_index_next = word_index + 2'd1;
      end
    end else begin
      if (b == CH_CR || b == CH_LF) begin
        cont = 1'b0;
      end else if (cur_kind == KIND_VALUE) begin
        cont = 1'b1;
      end else if (b == CH_SP) begin
        cont = 1'b0;
      end else if (b == CH_COLON) begin
        start = 1'b1;
        nk    = KIND_COLON;
      end else if (digit) begin
        if (cur_kind == KIND_NUMBER || cur_kind == KIND_HEADER) begin
          cont = 1'b1;
        end else begin
          start = 1'b1;
          nk    = KIND_NUMBER;
        end
      end else begin
        if (cur_kind == KIND_HEADER) begin
          cont = 1'b1;
        end else begin
          start = 1'b1;
          nk    = after_colon ? KIND_VALUE : KIND_HEADER;
        end
      end
      if (start) begin
        after_colon_next = (nk == KIND_COLON);
      end
    end
  end

  // held byte update
  always_comb begin
    held_byte_next  = held_byte;
    held_kind_next  = held_kind;
    held_first_next = held_first;
    cur_kind_next   = cur_kind;
    held_valid_next = 1'b0;
    if (cont) begin
      held_valid_next = 1'b1;
      held_byte_next  = b;
      held_kind_next  = cur_kind;
      held_first_next = 1'b0;
    end else if (start) begin
      held_valid_next = 1'b1;
      held_byte_next  = b;
      held_kind_next  = nk;
      held_first_next = 1'b1;
      cur_kind_next   = nk;
    end else begin
      cur_kind_next = KIND_NONE;
    end
  end

  // result packing: released held byte, then flush on the final byte
  always_comb begin
    e0 = '{tok_kind: held_kind, tok_byte: held_byte, tok_first: held_first,
           tok_last: ~cont, msg_done: 1'b0};
    e1 = '{tok_kind: held_kind_next, tok_byte: held_byte_next,
           tok_first: held_first_next, tok_last: 1'b1, msg_done: 1'b0};
    none_res = '{tok_kind: KIND_NONE, tok_byte: 8'd0, tok_first: 1'b0,
                 tok_last: 1'b0, msg_done: 1'b1};
    e1_valid   = data.in_final & held_valid_next;
    push.count = 2'd0;
    push.res0  = e0;
    push.res1  = e1;
    if (held_valid) begin
      push.count = e1_valid ? 2'd2 : 2'd1;
      if (e1_valid) begin
        push.res1.msg_done = 1'b1;
      end else begin
        push.res0.msg_done = data.in_final;
      end
    end else if (e1_valid) begin
      push.count         = 2'd1;
      push.res0          = e1;
      push.res0.msg_done = 1'b1;
    end else if (data.in_final) begin
      push.count = 2'd1;
      push.res0  = none_res;
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_request_line <= 1'b1;
      word_index      <= 2'd0;
      cur_kind        <= KIND_NONE;
      after_colon     <= 1'b0;
      held_valid      <= 1'b0;
      held_byte       <= 8'd0;
      held_kind       <= KIND_METHOD;
      held_first      <= 1'b0;
    end else if (fire) begin
      if (data.in_final) begin
        in_request_line <= 1'b1;
        word_index      <= 2'd0;
        cur_kind        <= KIND_NONE;
        after_colon     <= 1'b0;
        held_valid      <= 1'b0;
        held_byte       <= 8'd0;
        held_kind       <= KIND_METHOD;
        held_first      <= 1'b0;
      end else begin
        in_request_line <= in_request_line_next;
        word_index      <= word_index_next;
        cur_kind        <= cur_kind_next;
        after_colon     <= after_colon_next;
        held_valid      <= held_valid_next;
        held_byte       <= held_byte_next;
        held_kind       <= held_kind_next;
        held_first      <= held_first_next;
      end
    end
  end

endmodule

[hw/rtl/hrl_out_queue.sv]
// ----------------------------------------------------------------------------
// hrl_out_queue
// Small result buffer; takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module hrl_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_en,
  input  hrl_pkg::hrl_push_t push,
  output logic               has_room,
  output logic               tok_valid,
  input  logic               tok_ready,
  output hrl_pkg::hrl_out_t  tok_data
);
  import hrl_pkg::*;

  hrl_out_t       entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic [QAW:0]   count_next;
  logic [1:0]     n_push;
  logic           pop;

  assign n_push    = push_en ? push.count : 2'd0;
  assign pop       = tok_valid & tok_ready;
  assign tok_valid = (count != '0);
  assign tok_data  = entries[rd_ptr];
  // room for a full two-result step
  assign has_room  = (count <= (QAW+1)'(QDEPTH - 2));

  always_comb begin
    count_next = count + (QAW+1)'(n_push) - (QAW+1)'(pop);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(n_push);
      rd_ptr <= rd_ptr + QAW'(pop);
      count  <= count_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr + QAW'(1)] <= push.res1;
    end
  end

endmodule

[hw/rtl/http_request_lexer.sv]
// ----------------------------------------------------------------------------
// http_request_lexer
// Byte-wide HTTP request tokenizer with valid/ready streams on both sides.
// ----------------------------------------------------------------------------
// The lexer accepts one request byte per cycle on src while the result
// buffer has room and tags token bytes on tok. A byte is registered on
// entry, classified against the lexer state from the input register and its
// results (zero, one or two) go into a four-entry result buffer. Sustained
// intake is one byte per cycle while tok is drained at least as fast as
// results are made; a byte that yields two results needs a tok transfer for
// each, and the fill level of the result buffer sets when src is held off.
module http_request_lexer (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  hrl_pkg::hrl_in_t  src_data,
  output logic              tok_valid,
  input  logic              tok_ready,
  output hrl_pkg::hrl_out_t tok_data
);
  import hrl_pkg::*;

  hrl_in_t   stage;
  logic      stage_valid;
  logic      has_room;
  logic      fire;
  hrl_push_t push;

  assign fire      = stage_valid & has_room;
  assign src_ready = ~stage_valid | fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (src_ready) begin
      stage_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready & src_valid) begin
      stage <= src_data;
    end
  end

  // classification and lexer state
  hrl_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .data (stage),
    .push (push)
  );

  // result buffer
  hrl_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (fire),
    .push      (push),
    .has_room  (has_room),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_data  (tok_data)
  );

endmodule

[dv/token_checker.sv]
// ----------------------------------------------------------------------------
// token_checker
// Watches both streams of the http request lexer, works out the tokens that
// each accepted request byte must produce and compares them in order with
// the tokens that leave the block.
// ----------------------------------------------------------------------------
module token_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  input  logic              src_ready,
  input  hrl_pkg::hrl_in_t  src_data,
  input  logic              tok_valid,
  input  logic              tok_ready,
  input  hrl_pkg::hrl_out_t tok_data,
  output int                fail_count,
  output int                pending_count,
  output int                token_count
);
  import hrl_pkg::*;

  // lexer state as the predictor tracks it
  logic       on_start_line;
  logic [1:0] words_seen;
  kind_t      open_kind;
  logic       colon_last;
  logic       pend_valid;
  logic [7:0] pend_byte;
  kind_t      pend_kind;
  logic       pend_first;

  // tokens still owed by the block, oldest first
  hrl_out_t expected_tokens[$];

  task automatic clear_lexer();
    on_start_line = 1'b1;
    words_seen    = 2'd0;
    open_kind     = KIND_NONE;
    colon_last    = 1'b0;
    pend_valid    = 1'b0;
    pend_byte     = 8'h00;
    pend_kind     = KIND_METHOD;
    pend_first    = 1'b0;
  endtask

  task automatic owe_token(input kind_t k, input logic [7:0] b, input logic first,
                           input logic last);
    hrl_out_t t;
    t.tok_kind  = k;
    t.tok_byte  = b;
    t.tok_first = first;
    t.tok_last  = last;
    t.msg_done  = 1'b0;
    expected_tokens.push_back(t);
  endtask

  // classify one request byte and queue the tokens it releases
  task automatic lex_byte(input logic [7:0] b, input logic fin);
    logic  extend;
    logic  open;
    logic  is_digit;
    kind_t next_kind;
    int    size_before;
    extend      = 1'b0;
    open        = 1'b0;
    next_kind   = KIND_NONE;
    size_before = expected_tokens.size();
    is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);

    if (on_start_line) begin
      // request line: space separated words, cr ends the line
      if (b == CH_CR) begin
        on_start_line = 1'b0;
      end else if (b == CH_SP) begin
        // word separator
      end else if (open_kind != KIND_NONE) begin
        extend = 1'b1;
      end else if (words_seen < WORD_LIMIT) begin
        open      = 1'b1;
        next_kind = kind_t'({1'b0, words_seen});
        words_seen++;
      end
    end else begin
      // header lines
      if (b == CH_CR || b == CH_LF) begin
        // line break separator
      end else if (open_kind == KIND_VALUE) begin
        extend = 1'b1;
      end else if (b == CH_SP) begin
        // token separator
      end else if (b == CH_COLON) begin
        open      = 1'b1;
        next_kind = KIND_COLON;
      end else if (is_digit) begin
        if (open_kind == KIND_NUMBER || open_kind == KIND_HEADER) begin
          extend = 1'b1;
        end else begin
          open      = 1'b1;
          next_kind = KIND_NUMBER;
        end
      end else if (open_kind == KIND_HEADER) begin
        extend = 1'b1;
      end else begin
        open      = 1'b1;
        next_kind = colon_last ? KIND_VALUE : KIND_HEADER;
      end
      if (open) colon_last = (next_kind == KIND_COLON);
    end

    // release the held byte, flagged as last when its token closes
    if (extend) begin
      if (pend_valid) owe_token(pend_kind, pend_byte, pend_first, 1'b0);
      pend_valid = 1'b1;
      pend_byte  = b;
      pend_kind  = open_kind;
      pend_first = 1'b0;
    end else begin
      if (pend_valid) owe_token(pend_kind, pend_byte, pend_first, 1'b1);
      if (open) begin
        pend_valid = 1'b1;
        pend_byte  = b;
        pend_kind  = next_kind;
        pend_first = 1'b1;
        open_kind  = next_kind;
      end else begin
        pend_valid = 1'b0;
        open_kind  = KIND_NONE;
      end
    end

    // end of request flushes the held byte and marks the last token
    if (fin) begin
      if (pend_valid) owe_token(pend_kind, pend_byte, pend_first, 1'b1);
      if (expected_tokens.size() == size_before)
        owe_token(KIND_NONE, 8'h00, 1'b0, 1'b0);
      expected_tokens[expected_tokens.size() - 1].msg_done = 1'b1;
      clear_lexer();
    end
  endtask

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // compare one outgoing token with the oldest expected one
  task automatic check_token(input hrl_out_t got);
    hrl_out_t want;
    logic     bad;
    token_count++;
    if (expected_tokens.size() == 0) begin
      flag_failure($sformatf("unexpected token: kind %0d byte %02h first %0b last %0b done %0b",
                             got.tok_kind, got.tok_byte, got.tok_first, got.tok_last,
                             got.msg_done));
    end else begin
      want = expected_tokens.pop_front();
      bad  = (got.tok_kind !== want.tok_kind) || (got.tok_byte !== want.tok_byte) ||
             (got.tok_first !== want.tok_first) || (got.tok_last !== want.tok_last) ||
             (got.msg_done !== want.msg_done);
      if (bad)
        flag_failure($sformatf({"token %0d mismatch: expected kind %0d byte %02h first %0b",
                                " last %0b done %0b, got kind %0d byte %02h first %0b",
                                " last %0b done %0b"},
                               token_count, want.tok_kind, want.tok_byte, want.tok_first,
                               want.tok_last, want.msg_done, got.tok_kind, got.tok_byte,
                               got.tok_first, got.tok_last, got.msg_done));
    end
  endtask

  // predict on accepted requests, check on accepted tokens
  always @(posedge clk) begin
    if (rst) begin
      clear_lexer();
      expected_tokens.delete();
    end else begin
      if (src_valid && src_ready) lex_byte(src_data.in_byte, src_data.in_final);
      if (tok_valid && tok_ready) check_token(tok_data);
    end
    pending_count = expected_tokens.size();
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the http request lexer with a few hand-made requests and then with
// random requests, mostly well formed, some broken and some pure noise, under
// random gaps on the input and random stalls on the token stream.
// ----------------------------------------------------------------------------
module testbench;
  import hrl_pkg::*;

  localparam int RANDOM_BYTES = 650;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;
  typedef enum {CLS_ALPHA, CLS_DIGIT, CLS_PRINT, CLS_TEXT, CLS_MARK, CLS_ANY} char_class_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  hrl_in_t   src_data = '0;
  logic      tok_valid;
  logic      tok_ready = 1'b0;
  hrl_out_t  tok_data;

  int         fail_count;
  int         pending_count;
  int         token_count;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         random_bytes = 0;
  int         requests_sent = 0;
  int         stall_left = 0;
  idle_mode_t src_mode = IDLE_LIGHT;
  idle_mode_t sink_mode = IDLE_LIGHT;
  logic [7:0] req_bytes[$];

  http_request_lexer uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_data  (tok_data)
  );

  token_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .src_valid     (src_valid),
    .src_ready     (src_ready),
    .src_data      (src_data),
    .tok_valid     (tok_valid),
    .tok_ready     (tok_ready),
    .tok_data      (tok_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .token_count   (token_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap lengths: mostly short, now and then long
  function automatic int pick_gap(idle_mode_t m);
    int r;
    r = $urandom_range(0, 99);
    if (m == IDLE_NONE) return 0;
    if (m == IDLE_LIGHT) begin
      if (r < 75) return 0;
      if (r < 98) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
    end
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 30);
  endfunction

  // token stream stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      tok_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pick_gap(sink_mode) > 0) begin
      tok_ready  <= 1'b0;
      stall_left <= pick_gap(IDLE_HEAVY);
    end else begin
      tok_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] pick_char(char_class_t c);
    case (c)
      CLS_ALPHA: return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
      CLS_DIGIT: return CH_ZERO + 8'($urandom_range(0, 9));
      CLS_PRINT: return 8'($urandom_range(8'h21, 8'h7E));
      CLS_TEXT:  return 8'($urandom_range(CH_SP, 8'h7E));
      CLS_MARK: begin
        case ($urandom_range(0, 5))
          0: return CH_SP;
          1: return CH_COLON;
          2: return CH_CR;
          3: return CH_LF;
          4: return CH_ZERO;
          default: return CH_NINE;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  task automatic push_run(input int len, input char_class_t c);
    for (int i = 0; i < len; i++) req_bytes.push_back(pick_char(c));
  endtask

  task automatic push_spaces();
    repeat ($urandom_range(1, 2)) req_bytes.push_back(CH_SP);
  endtask

  task automatic push_crlf();
    req_bytes.push_back(CH_CR);
    req_bytes.push_back(CH_LF);
  endtask

  // request line and a few header lines with random content
  task automatic build_wellformed();
    push_run($urandom_range(1, 6), CLS_ALPHA);
    push_spaces();
    push_run($urandom_range(1, 8), CLS_PRINT);
    push_spaces();
    push_run($urandom_range(1, 6), CLS_PRINT);
    if ($urandom_range(0, 3) == 0) begin
      push_spaces();
      push_run($urandom_range(1, 4), CLS_PRINT);
    end
    push_crlf();
    repeat ($urandom_range(0, 3)) begin
      push_run($urandom_range(1, 6), CLS_ALPHA);
      if ($urandom_range(0, 3) == 0) push_run($urandom_range(1, 2), CLS_DIGIT);
      req_bytes.push_back(CH_COLON);
      if ($urandom_range(0, 1)) req_bytes.push_back(CH_SP);
      case ($urandom_range(0, 2))
        0: push_run($urandom_range(1, 5), CLS_DIGIT);
        1: push_run($urandom_range(1, 8), CLS_TEXT);
        default: push_run($urandom_range(1, 4), CLS_ANY);
      endcase
      if ($urandom_range(0, 4) == 0) req_bytes.push_back(CH_LF);
      else push_crlf();
    end
    if ($urandom_range(0, 1)) push_crlf();
  endtask

  // one request byte through the valid/ready handshake
  task automatic send_byte(input logic [7:0] b, input logic fin);
    hrl_in_t item;
    int      gap;
    gap = pick_gap(src_mode);
    item.in_byte  = b;
    item.in_final = fin;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= item;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_request();
    for (int i = 0; i < req_bytes.size(); i++)
      send_byte(req_bytes[i], i == req_bytes.size() - 1);
    requests_sent++;
    req_bytes.delete();
  endtask

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int sent_before;
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // request line without cr: lf inside the uri, a fourth word dropped,
    // and a final byte that leaves nothing to report
    push_str("G u");
    req_bytes.push_back(CH_LF);
    push_str(" x y");
    send_request();

    // empty request line, header with a digit, colon then line break then
    // value holding space, colon and 8'hff, number, header ending on byte 0
    req_bytes.push_back(CH_CR);
    push_str("h9:");
    req_bytes.push_back(CH_LF);
    push_str("v :");
    req_bytes.push_back(8'hFF);
    req_bytes.push_back(CH_CR);
    push_str("09/");
    req_bytes.push_back(8'h00);
    send_request();

    // random requests: mostly well formed, some broken, some noise
    while (random_bytes < RANDOM_BYTES) begin
      src_mode  = idle_mode_t'($urandom_range(0, 2));
      sink_mode = idle_mode_t'($urandom_range(0, 2));
      k = $urandom_range(0, 99);
      if (k < 85) begin
        build_wellformed();
        if (k >= 70) begin
          if ($urandom_range(0, 1)) begin
            k = $urandom_range(1, req_bytes.size());
            while (req_bytes.size() > k) void'(req_bytes.pop_back());
          end else begin
            repeat ($urandom_range(1, 3))
              req_bytes[$urandom_range(0, req_bytes.size() - 1)] =
                pick_char($urandom_range(0, 1) ? CLS_MARK : CLS_ANY);
          end
        end
      end else begin
        repeat ($urandom_range(1, 12))
          req_bytes.push_back(pick_char($urandom_range(0, 1) ? CLS_MARK : CLS_ANY));
      end
      sent_before = bytes_sent;
      send_request();
      random_bytes += bytes_sent - sent_before;
    end

    // drain with no new stalls started on the token stream
    src_valid <= 1'b0;
    sink_mode = IDLE_NONE;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request bytes in %0d requests (hand-made, well formed, broken, noise)",
             bytes_sent, requests_sent);
    $display("Checked %0d tokens under random input gaps and output stalls", token_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
